[src/assert_macros.svh]
// Concurrent assertion helpers; expect clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/cvru_pkg.sv]
package cvru_pkg;

	localparam int DATA_WIDTH   = 24;
	localparam int FRAC_BITS    = 16;
	localparam int ITER_DEFAULT = 16;
	localparam int ITER_MAX     = 32;

	// internal datapath widths: x/y carry the CORDIC gain, z the angle sum
	localparam int IW = DATA_WIDTH + 3;
	localparam int ZW = DATA_WIDTH + 2;
	localparam int KW = FRAC_BITS + 1;
	localparam int AW = FRAC_BITS + 1;

	localparam logic signed [ZW-1:0] PI_FIX   = ZW'(205887);
	localparam logic [KW-1:0]        KINV_FIX = KW'(39797);

	// atan(2^-i), rounded to FRAC_BITS fraction bits
	localparam logic [AW-1:0] ATAN_LUT [ITER_MAX] = '{
		AW'(51472), AW'(30386), AW'(16055), AW'(8150),
		AW'(4091),  AW'(2047),  AW'(1024),  AW'(512),
		AW'(256),   AW'(128),   AW'(64),    AW'(32),
		AW'(16),    AW'(8),     AW'(4),     AW'(2),
		AW'(1),     AW'(0),     AW'(0),     AW'(0),
		AW'(0),     AW'(0),     AW'(0),     AW'(0),
		AW'(0),     AW'(0),     AW'(0),     AW'(0),
		AW'(0),     AW'(0),     AW'(0),     AW'(0)
	};

	typedef enum logic {
		OP_VECTOR = 1'b0,
		OP_ROTATE = 1'b1
	} op_t;

	typedef struct packed {
		op_t                          opcode;
		logic signed [DATA_WIDTH-1:0] x_value;
		logic signed [DATA_WIDTH-1:0] y_value;
		logic signed [DATA_WIDTH-1:0] angle_in;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] first_result;
		logic signed [DATA_WIDTH-1:0] second_result;
	} rsp_t;

	function automatic logic signed [DATA_WIDTH-1:0] sat_iw(input logic signed [IW-1:0] v);
		logic [IW-DATA_WIDTH:0] top;
		top = v[IW-1:DATA_WIDTH-1];
		if (top == '0 || top == '1)
			return signed'(v[DATA_WIDTH-1:0]);
		else if (v[IW-1])
			return signed'({1'b1, {(DATA_WIDTH-1){1'b0}}});
		else
			return signed'({1'b0, {(DATA_WIDTH-1){1'b1}}});
	endfunction

endpackage

[src/cordic_vectoring_rotation_unit.sv]
// Stages (ITERATIONS + 3): preprocess, one per micro-rotation, gain multiply,
// saturate/output register. Throughput: one item per cycle while rsp_stall is
// low; each stage advances on its own, so bubbles collapse and, while any stage
// is empty, new commands are taken while a finished result is stalled.
// Reset: arst_n clears all stage valid bits; data registers are not reset.
module cordic_vectoring_rotation_unit #(
	parameter int ITERATIONS = cvru_pkg::ITER_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  cvru_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cvru_pkg::rsp_t rsp
);
	import cvru_pkg::*;

	localparam int NST = ITERATIONS + 3;
	localparam int PW  = IW - 1 + KW;
	localparam int MW  = PW - FRAC_BITS;

	logic [NST-1:0] vld_q;
	logic [NST:0]   rdy;

	// stage 1: quadrant fold / rotation seed
	logic signed [IW-1:0] pre_x, pre_y, xi, yi;
	logic signed [ZW-1:0] pre_z;
	logic signed [IW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	op_t                  op_s1;

	// stage 2 bank: one register set per micro-rotation
	logic signed [IW-1:0] x_s2 [ITERATIONS];
	logic signed [IW-1:0] y_s2 [ITERATIONS];
	logic signed [ZW-1:0] z_s2 [ITERATIONS];
	op_t                  op_s2 [ITERATIONS];

	// stage 3: gain multiply
	logic [IW-2:0]        xc;
	logic [PW-1:0]        prod_s3;
	logic signed [IW-1:0] x_s3, sec_s3;
	op_t                  op_s3;

	// stage 4: output register
	logic [MW-1:0]        mag;
	rsp_t                 rsp_s4;

	assign rdy[NST] = !rsp_stall;
	for (genvar k = 0; k < NST; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign cmd_stall = !rdy[0];
	assign rsp_valid = vld_q[NST-1];
	assign rsp       = rsp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0])
				vld_q[0] <= cmd_valid;
			for (int k = 1; k < NST; k++) begin
				if (rdy[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_comb begin
		xi = IW'(cmd.x_value);
		yi = IW'(cmd.y_value);
		pre_x = xi;
		pre_y = yi;
		pre_z = '0;
		if (cmd.opcode == OP_ROTATE) begin
			pre_x = IW'(KINV_FIX);
			pre_y = '0;
			pre_z = ZW'(cmd.angle_in);
		end else if (cmd.x_value[DATA_WIDTH-1]) begin
			pre_x = -xi;
			pre_y = -yi;
			pre_z = cmd.y_value[DATA_WIDTH-1] ? -PI_FIX : PI_FIX;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			x_s1  <= pre_x;
			y_s1  <= pre_y;
			z_s1  <= pre_z;
			op_s1 <= cmd.opcode;
		end
	end

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
		logic signed [IW-1:0] xp, yp;
		logic signed [ZW-1:0] zp, ang;
		op_t                  opp;
		logic                 plus;

		if (k == 0) begin : g_first
			assign xp  = x_s1;
			assign yp  = y_s1;
			assign zp  = z_s1;
			assign opp = op_s1;
		end else begin : g_next
			assign xp  = x_s2[k-1];
			assign yp  = y_s2[k-1];
			assign zp  = z_s2[k-1];
			assign opp = op_s2[k-1];
		end

		assign ang = ZW'({1'b0, ATAN_LUT[k]});
		// plus: x -= y>>k, y += x>>k, z -= atan
		assign plus = (opp == OP_ROTATE) ? !zp[ZW-1] : yp[IW-1];

		always_ff @(posedge clk) begin
			if (rdy[k+1]) begin
				x_s2[k]  <= plus ? xp - (yp >>> k) : xp + (yp >>> k);
				y_s2[k]  <= plus ? yp + (xp >>> k) : yp - (xp >>> k);
				z_s2[k]  <= plus ? zp - ang : zp + ang;
				op_s2[k] <= opp;
			end
		end
	end

	assign xc = x_s2[ITERATIONS-1][IW-1] ? '0 : x_s2[ITERATIONS-1][IW-2:0];

	always_ff @(posedge clk) begin
		if (rdy[ITERATIONS+1]) begin
			prod_s3 <= PW'(xc) * PW'(KINV_FIX);
			x_s3    <= x_s2[ITERATIONS-1];
			sec_s3  <= (op_s2[ITERATIONS-1] == OP_ROTATE) ? y_s2[ITERATIONS-1]
			                                              : IW'(z_s2[ITERATIONS-1]);
			op_s3   <= op_s2[ITERATIONS-1];
		end
	end

	assign mag = prod_s3[PW-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (rdy[ITERATIONS+2]) begin
			if (op_s3 == OP_ROTATE)
				rsp_s4.first_result <= sat_iw(x_s3);
			else if (|mag[MW-1:DATA_WIDTH-1])
				rsp_s4.first_result <= signed'({1'b0, {(DATA_WIDTH-1){1'b1}}});
			else
				rsp_s4.first_result <= signed'(mag[DATA_WIDTH-1:0]);
			rsp_s4.second_result <= sat_iw(sec_s3);
		end
	end

endmodule

[src/cvru_checker.sv]
`include "assert_macros.svh"

module cvru_checker #(
	parameter int ITERATIONS = cvru_pkg::ITER_DEFAULT
) (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input cvru_pkg::cmd_t cmd,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input cvru_pkg::rsp_t rsp
);
	import cvru_pkg::*;

	localparam int DEPTH = ITERATIONS + 3;
	localparam int CW    = $clog2(DEPTH + 1) + 1;

	logic          cmd_xfer, rsp_xfer;
	logic [CW-1:0] cnt_q;

	assign cmd_xfer = cmd_valid && !cmd_stall;
	assign rsp_xfer = rsp_valid && !rsp_stall;

	// items taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + CW'(cmd_xfer) - CW'(rsp_xfer);
	end

	`ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")
	`ASSERT_NOW(a_rsp_has_cmd, rsp_valid, cnt_q != '0, "rsp valid with no command in flight")
	`ASSERT_NOW(a_depth, cmd_xfer, cnt_q <= CW'(DEPTH), "more items in flight than pipeline stages")
	`ASSERT_NOW(a_no_idle_stall, !rsp_valid, !cmd_stall, "cmd stalled while output register is empty")

endmodule

bind cordic_vectoring_rotation_unit cvru_checker #(.ITERATIONS(ITERATIONS)) u_cvru_checker (.*);
